@@ design/vcrl_pkg.sv @@
// Package with shared types, codes and helpers of the verdict cache rate limiter.
`timescale 1ns / 1ps
`default_nettype none
package vcrl_pkg;

    localparam int VCRL_ENTRIES = 64;

    localparam logic [2:0] ACT_INBOUND  = 3'd0;
    localparam logic [2:0] ACT_OUTBOUND = 3'd1;
    localparam logic [2:0] ACT_UPDATE   = 3'd2;
    localparam logic [2:0] ACT_FLUSH    = 3'd3;
    localparam logic [2:0] ACT_TICK     = 3'd4;

    localparam logic [2:0] VERD_DROP       = 3'd1;
    localparam logic [2:0] VERD_RATE_LIMIT = 3'd2;
    localparam logic [2:0] VERD_QUARANTINE = 3'd4;

    localparam logic [2:0] MODE_DETECT  = 3'd2;
    localparam logic [2:0] MODE_PROTECT = 3'd3;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_MODE   = 2'd1;
    localparam logic [1:0] CFG_TPS    = 2'd2;

    localparam logic [3:0] CAUSE_FILTER_OFF = 4'd0;
    localparam logic [3:0] CAUSE_MODE_LOW   = 4'd1;
    localparam logic [3:0] CAUSE_NO_ENTRY   = 4'd2;
    localparam logic [3:0] CAUSE_EXPIRED    = 4'd3;
    localparam logic [3:0] CAUSE_ALLOW      = 4'd4;
    localparam logic [3:0] CAUSE_DROP       = 4'd5;
    localparam logic [3:0] CAUSE_RATE       = 4'd6;
    localparam logic [3:0] CAUSE_UPDATED    = 4'd7;
    localparam logic [3:0] CAUSE_INSERTED   = 4'd8;
    localparam logic [3:0] CAUSE_FULL       = 4'd9;
    localparam logic [3:0] CAUSE_FLUSHED    = 4'd10;
    localparam logic [3:0] CAUSE_TICK       = 4'd11;

    localparam logic [15:0] DEFAULT_DURATION = 16'd300;
    localparam logic [15:0] DEFAULT_TPS      = 16'd1000;

    typedef enum logic [2:0] {
        OP_RESULT,
        OP_LOOKUP,
        OP_UPDATE,
        OP_FLUSH,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  cause;
        logic [31:0] key;
        logic [2:0]  verdict;
        logic [31:0] limit;
        logic [15:0] duration;
    } t_job;

    function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage
`default_nettype wire

@@ design/vcrl_front.sv @@
// Front end: accepts beats, classifies them into jobs and queues them for the table engine.
`timescale 1ns / 1ps
`default_nettype none
module vcrl_front import vcrl_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_action,
    input  wire logic [31:0] i_src_addr,
    input  wire logic [31:0] i_dst_addr,
    input  wire logic [2:0]  i_verdict_code,
    input  wire logic [31:0] i_rate_limit,
    input  wire logic [15:0] i_duration,
    input  wire logic        i_filter_enable,
    input  wire logic [2:0]  i_filter_mode,
    input  wire logic        i_hold,
    output logic             o_job_valid,
    input  wire logic        i_job_ready,
    output t_job             o_job
);

    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_job       w_job;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_job          = '0;
        w_job.op       = OP_RESULT;
        w_job.cause    = CAUSE_FILTER_OFF;
        w_job.key      = i_src_addr;
        w_job.verdict  = i_verdict_code;
        w_job.limit    = i_rate_limit;
        w_job.duration = i_duration;
        case (i_action)
            ACT_INBOUND, ACT_OUTBOUND: begin
                if (i_action == ACT_OUTBOUND) begin
                    w_job.key = i_dst_addr;
                end
                if (!i_filter_enable) begin
                    w_job.cause = CAUSE_FILTER_OFF;
                end else if (i_filter_mode < MODE_PROTECT) begin
                    w_job.cause = CAUSE_MODE_LOW;
                end else begin
                    w_job.op = OP_LOOKUP;
                end
            end
            ACT_UPDATE: w_job.op = OP_UPDATE;
            ACT_FLUSH:  w_job.op = OP_FLUSH;
            ACT_TICK:   w_job.op = OP_TICK;
            default:    w_job.op = OP_RESULT;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2) && !i_hold;
    assign w_push      = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop       = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_job;
                r_wp      <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule
`default_nettype wire

@@ design/vcrl_back.sv @@
// Table engine: scans the verdict table, applies lookups and updates, and holds the result beat.
`timescale 1ns / 1ps
`default_nettype none
module vcrl_back import vcrl_pkg::*; #(
    parameter int ENTRIES = VCRL_ENTRIES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_job_valid,
    output logic             o_job_ready,
    input  t_job             i_job,
    input  wire logic [15:0] i_tps,
    output logic             o_init,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_accept,
    output logic [3:0]       o_cause
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
    localparam logic [AW-1:0] ONE  = AW'(1);

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [2:0]  verdict;
        logic [31:0] limit;
        logic [31:0] expiry;
        logic [31:0] wcount;
        logic [31:0] wstart;
    } t_entry;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_EVAL  = 6'b000100,
        S_RATE  = 6'b001000,
        S_CLEAR = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_entry      r_mem [ENTRIES];
    t_entry      r_rd;
    t_state      r_state;
    logic [AW-1:0] r_addr;
    logic        r_issue;
    logic        r_chk_vld;
    logic [AW-1:0] r_chk_idx;
    t_job        r_job;
    logic        r_found;
    logic [AW-1:0] r_hit_idx;
    t_entry      r_hit;
    logic        r_free_found;
    logic [AW-1:0] r_free_idx;
    logic [31:0] r_prod;
    logic [31:0] r_tick;
    logic        r_restart;
    logic        r_flush;
    logic        r_res_acc;
    logic [3:0]  r_res_cause;
    logic        r_out_vld;
    logic        r_out_acc;
    logic [3:0]  r_out_cause;

    logic        w_we;
    logic [AW-1:0] w_wa;
    t_entry      w_wd;
    logic [31:0] w_exp;
    logic        w_expired;
    logic [31:0] w_cnt_base;
    logic [31:0] w_cnt_new;
    logic [15:0] w_dur;
    logic        w_load;

    assign o_job_ready = (r_state == S_IDLE);
    assign o_init      = (r_state == S_CLEAR) && !r_flush;
    assign o_valid     = r_out_vld;
    assign o_accept    = r_out_acc;
    assign o_cause     = r_out_cause;

    assign w_dur      = (i_job.duration == 16'd0) ? DEFAULT_DURATION : i_job.duration;
    assign w_exp      = r_tick + r_prod;
    assign w_expired  = later_than(r_tick, r_hit.expiry);
    assign w_cnt_base = r_restart ? 32'd0 : r_hit.wcount;
    assign w_cnt_new  = (w_cnt_base == 32'hFFFF_FFFF) ? w_cnt_base : w_cnt_base + 32'd1;
    assign w_load     = (r_state == S_DONE) && (!r_out_vld || i_ready);

    always_comb begin
        w_we = 1'b0;
        w_wa = r_addr;
        w_wd = r_hit;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                w_wd = '0;
            end
            S_EVAL: begin
                if (r_job.op == OP_UPDATE) begin
                    if (r_found) begin
                        w_we         = 1'b1;
                        w_wa         = r_hit_idx;
                        w_wd.verdict = r_job.verdict;
                        w_wd.limit   = r_job.limit;
                        w_wd.expiry  = w_exp;
                    end else if (r_free_found) begin
                        w_we         = 1'b1;
                        w_wa         = r_free_idx;
                        w_wd.valid   = 1'b1;
                        w_wd.key     = r_job.key;
                        w_wd.verdict = r_job.verdict;
                        w_wd.limit   = r_job.limit;
                        w_wd.expiry  = w_exp;
                        w_wd.wcount  = 32'd0;
                        w_wd.wstart  = r_tick;
                    end
                end else if (r_found && w_expired) begin
                    w_we       = 1'b1;
                    w_wa       = r_hit_idx;
                    w_wd.valid = 1'b0;
                end
            end
            S_RATE: begin
                w_we        = 1'b1;
                w_wa        = r_hit_idx;
                w_wd.wcount = w_cnt_new;
                w_wd.wstart = r_restart ? r_tick : r_hit.wstart;
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_flush   <= 1'b0;
            r_tick    <= 32'd0;
            r_out_vld <= 1'b0;
            r_issue   <= 1'b0;
            r_chk_vld <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job       <= i_job;
                        r_res_acc   <= 1'b1;
                        r_res_cause <= (i_job.op == OP_TICK) ? CAUSE_TICK : i_job.cause;
                        r_addr      <= '0;
                        unique case (i_job.op)
                            OP_TICK: begin
                                r_tick  <= r_tick + 32'd1;
                                r_state <= S_DONE;
                            end
                            OP_FLUSH: begin
                                r_flush <= 1'b1;
                                r_state <= S_CLEAR;
                            end
                            OP_LOOKUP, OP_UPDATE: begin
                                r_issue      <= 1'b1;
                                r_chk_vld    <= 1'b0;
                                r_found      <= 1'b0;
                                r_free_found <= 1'b0;
                                r_prod       <= {16'd0, w_dur} * {16'd0, i_tps};
                                r_state      <= S_SCAN;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_chk_vld <= r_issue;
                    r_chk_idx <= r_addr;
                    if (r_issue) begin
                        if (r_addr == LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + ONE;
                        end
                    end
                    if (r_chk_vld) begin
                        if (r_rd.valid && (r_rd.key == r_job.key) && !r_found) begin
                            r_found   <= 1'b1;
                            r_hit_idx <= r_chk_idx;
                            r_hit     <= r_rd;
                        end
                        if (!r_rd.valid && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_chk_idx;
                        end
                        if (r_chk_idx == LAST) begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    if (r_job.op == OP_UPDATE) begin
                        r_state <= S_DONE;
                        if (r_found) begin
                            r_res_cause <= CAUSE_UPDATED;
                        end else if (r_free_found) begin
                            r_res_cause <= CAUSE_INSERTED;
                        end else begin
                            r_res_cause <= CAUSE_FULL;
                        end
                    end else if (!r_found) begin
                        r_state     <= S_DONE;
                        r_res_cause <= CAUSE_NO_ENTRY;
                    end else if (w_expired) begin
                        r_state     <= S_DONE;
                        r_res_cause <= CAUSE_EXPIRED;
                    end else if ((r_hit.verdict == VERD_DROP)
                                 || (r_hit.verdict == VERD_QUARANTINE)) begin
                        r_state     <= S_DONE;
                        r_res_acc   <= 1'b0;
                        r_res_cause <= CAUSE_DROP;
                    end else if ((r_hit.verdict == VERD_RATE_LIMIT)
                                 && (r_hit.limit != 32'd0)) begin
                        r_restart <= later_than(r_tick, r_hit.wstart + {16'd0, i_tps});
                        r_state   <= S_RATE;
                    end else begin
                        r_state     <= S_DONE;
                        r_res_cause <= CAUSE_ALLOW;
                    end
                end
                S_RATE: begin
                    r_state <= S_DONE;
                    if (w_cnt_new > r_hit.limit) begin
                        r_res_acc   <= 1'b0;
                        r_res_cause <= CAUSE_RATE;
                    end else begin
                        r_res_cause <= CAUSE_ALLOW;
                    end
                end
                S_CLEAR: begin
                    if (r_addr == LAST) begin
                        r_addr  <= '0;
                        r_flush <= 1'b0;
                        if (r_flush) begin
                            r_res_acc   <= 1'b1;
                            r_res_cause <= CAUSE_FLUSHED;
                            r_state     <= S_DONE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_addr <= r_addr + ONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_out_acc   <= r_res_acc;
                        r_out_cause <= r_res_cause;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ design/ip_verdict_cache_rate_limiter.sv @@
// Top level of the per-address verdict cache with fixed-window rate limiting.
`timescale 1ns / 1ps
`default_nettype none
// Packets are looked up by address in a table of ENTRIES verdict entries held in one
// memory with a single registered read port that is scanned one entry per cycle. A packet
// lookup or an update scans the whole table (a rate-limited entry is then counted in a
// further step), a flush clears every entry, and a tick or a packet that needs no lookup
// goes straight to the result; the table engine handles one beat at a time, so the table
// scan sets the rate, and a result beat that is not taken holds the engine. After reset a
// clearing pass over all ENTRIES entries runs before the first beat is accepted. A two-deep
// queue between the front end and the table engine, and the output register, let either
// side stall.
module ip_verdict_cache_rate_limiter import vcrl_pkg::*; #(
    parameter int ENTRIES = VCRL_ENTRIES
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // src_addr[31:0], dst_addr[63:32], verdict_code[66:64], rate_limit[98:67],
    // duration[114:99], zero fill[119:115]
    input  wire logic [119:0] i_s_axis_tdata,
    // action[2:0]
    input  wire logic [2:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // accept[0], cause[4:1], zero fill[7:5]
    output logic [7:0]        o_m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [15:0]  i_cfg_data
);

    logic        r_filter_enable;
    logic [2:0]  r_filter_mode;
    logic [15:0] r_tps;
    logic        w_job_valid;
    logic        w_job_ready;
    t_job        w_job;
    logic        w_init;
    logic        w_accept;
    logic [3:0]  w_cause;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_enable <= 1'b1;
            r_filter_mode   <= MODE_DETECT;
            r_tps           <= DEFAULT_TPS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: r_filter_enable <= i_cfg_data[0];
                CFG_MODE:   r_filter_mode   <= i_cfg_data[2:0];
                CFG_TPS:    r_tps           <= i_cfg_data;
                default:    r_tps           <= r_tps;
            endcase
        end
    end

    vcrl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_action       (i_s_axis_tuser),
        .i_src_addr     (i_s_axis_tdata[31:0]),
        .i_dst_addr     (i_s_axis_tdata[63:32]),
        .i_verdict_code (i_s_axis_tdata[66:64]),
        .i_rate_limit   (i_s_axis_tdata[98:67]),
        .i_duration     (i_s_axis_tdata[114:99]),
        .i_filter_enable(r_filter_enable),
        .i_filter_mode  (r_filter_mode),
        .i_hold         (w_init),
        .o_job_valid    (w_job_valid),
        .i_job_ready    (w_job_ready),
        .o_job          (w_job)
    );

    vcrl_back #(
        .ENTRIES(ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(w_job_valid),
        .o_job_ready(w_job_ready),
        .i_job      (w_job),
        .i_tps      (r_tps),
        .o_init     (w_init),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_accept   (w_accept),
        .o_cause    (w_cause)
    );

    assign o_m_axis_tdata = {3'b000, w_cause, w_accept};

endmodule
`default_nettype wire

@@ bench/tb_ip_verdict_cache_rate_limiter.sv @@
// Self-checking testbench for the per-address verdict cache with rate limiting.
`timescale 1ns / 1ps
`default_nettype none
module tb_ip_verdict_cache_rate_limiter;
    import vcrl_pkg::*;

    localparam logic [2:0] ACT_UNKNOWN = 3'd7;
    localparam logic [2:0] VERD_ALLOW = 3'd0;
    localparam logic [2:0] VERD_REDIRECT = 3'd3;
    localparam logic [2:0] MODE_DETECT = 3'd2;
    localparam logic [2:0] MODE_QUARANTINE = 3'd4;
    localparam logic [2:0] MODE_TOP = 3'd7;
    localparam int POOL_SIZE = 72;

    typedef struct {
        logic [2:0]  act;
        logic [31:0] src;
        logic [31:0] dst;
        logic [2:0]  verd;
        logic [31:0] lim;
        logic [15:0] dur;
    } req_t;

    typedef struct {
        logic       accept;
        logic [3:0] cause;
    } verdict_t;

    class verdict_table_sb;
        logic        filt_en;
        logic [2:0]  filt_mode;
        logic [15:0] tps;
        logic        valid[VCRL_ENTRIES];
        logic [31:0] key[VCRL_ENTRIES];
        logic [2:0]  verd[VCRL_ENTRIES];
        logic [31:0] lim[VCRL_ENTRIES];
        logic [31:0] expiry[VCRL_ENTRIES];
        logic [31:0] wcount[VCRL_ENTRIES];
        logic [31:0] wstart[VCRL_ENTRIES];
        logic [31:0] now;
        verdict_t    expected_q[$];
        int          errors;

        function new();
            filt_en = 1'b1;
            filt_mode = MODE_DETECT;
            tps = DEFAULT_TPS;
            foreach (valid[i]) valid[i] = 1'b0;
            now = 0;
            errors = 0;
        endfunction

        function void set_cfg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_ENABLE: filt_en = data[0];
                CFG_MODE: filt_mode = data[2:0];
                CFG_TPS: tps = data;
                default: ;
            endcase
        endfunction

        function logic later(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            return (d != 0) && !d[31];
        endfunction

        function int find(logic [31:0] k);
            for (int i = 0; i < VCRL_ENTRIES; i++)
                if (valid[i] && key[i] == k) return i;
            return -1;
        endfunction

        function verdict_t lookup(logic [31:0] k);
            verdict_t r;
            int i;
            r.accept = 1'b1;
            if (!filt_en) begin
                r.cause = CAUSE_FILTER_OFF;
                return r;
            end
            if (filt_mode < MODE_PROTECT) begin
                r.cause = CAUSE_MODE_LOW;
                return r;
            end
            i = find(k);
            if (i < 0) begin
                r.cause = CAUSE_NO_ENTRY;
                return r;
            end
            if (later(now, expiry[i])) begin
                valid[i] = 1'b0;
                r.cause = CAUSE_EXPIRED;
                return r;
            end
            r.cause = CAUSE_ALLOW;
            if (verd[i] == VERD_DROP || verd[i] == VERD_QUARANTINE) begin
                r.accept = 1'b0;
                r.cause = CAUSE_DROP;
            end else if (verd[i] == VERD_RATE_LIMIT && lim[i] != 0) begin
                if (later(now, wstart[i] + 32'(tps))) begin
                    wcount[i] = 0;
                    wstart[i] = now;
                end
                if (wcount[i] != 32'hFFFF_FFFF) wcount[i] = wcount[i] + 1;
                if (wcount[i] > lim[i]) begin
                    r.accept = 1'b0;
                    r.cause = CAUSE_RATE;
                end
            end
            return r;
        endfunction

        function logic [3:0] upsert(req_t q);
            logic [31:0] d;
            logic [31:0] e;
            int i;
            d = (q.dur == 0) ? 32'(DEFAULT_DURATION) : 32'(q.dur);
            e = now + d * 32'(tps);
            i = find(q.src);
            if (i >= 0) begin
                verd[i] = q.verd;
                lim[i] = q.lim;
                expiry[i] = e;
                return CAUSE_UPDATED;
            end
            for (i = 0; i < VCRL_ENTRIES; i++) begin
                if (!valid[i]) begin
                    valid[i] = 1'b1;
                    key[i] = q.src;
                    verd[i] = q.verd;
                    lim[i] = q.lim;
                    expiry[i] = e;
                    wcount[i] = 0;
                    wstart[i] = now;
                    return CAUSE_INSERTED;
                end
            end
            return CAUSE_FULL;
        endfunction

        function void note_input(req_t q);
            verdict_t r;
            r.accept = 1'b1;
            case (q.act)
                ACT_INBOUND: r = lookup(q.src);
                ACT_OUTBOUND: r = lookup(q.dst);
                ACT_UPDATE: r.cause = upsert(q);
                ACT_FLUSH: begin
                    foreach (valid[i]) valid[i] = 1'b0;
                    r.cause = CAUSE_FLUSHED;
                end
                ACT_TICK: begin
                    now = now + 1;
                    r.cause = CAUSE_TICK;
                end
                default: r.cause = CAUSE_FILTER_OFF;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [7:0] data);
            verdict_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected result beat %h", data);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (data[0] !== e.accept) begin
                $error("accept: expected %0d, got %0d", e.accept, data[0]);
                errors++;
            end
            if (data[4:1] !== e.cause) begin
                $error("cause: expected %0d, got %0d", e.cause, data[4:1]);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [119:0] i_s_axis_tdata = '0;
    logic [2:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [7:0]   o_m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_idx = '0;
    logic [15:0]  i_cfg_data = '0;

    verdict_table_sb sb = new();
    logic [31:0] addr_pool[POOL_SIZE];
    int result_beats = 0;

    ip_verdict_cache_rate_limiter i_dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    initial begin
        int stall;
        bit held;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (!held && result_beats >= 300) begin
                held = 1;
                i_m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            stall = (result_beats > 900 && result_beats < 1000) ? 0 : gap_len();
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall - 1) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(o_m_axis_tdata);
            result_beats <= result_beats + 1;
        end
    end

    task automatic send_req(req_t q);
        int g;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= q.act;
        i_s_axis_tdata <= {5'b0, q.dur, q.lim, q.verd, q.dst, q.src};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(q);
        g = gap_len();
        if (g > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_one(logic [2:0] act, logic [31:0] src, logic [31:0] dst,
                            logic [2:0] verd, logic [31:0] lim, logic [15:0] dur);
        req_t q;
        q.act = act;
        q.src = src;
        q.dst = dst;
        q.verd = verd;
        q.lim = lim;
        q.dur = dur;
        send_req(q);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_cfg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_all(logic en, logic [2:0] mode, logic [15:0] tps);
        write_cfg(CFG_ENABLE, {15'b0, en});
        write_cfg(CFG_MODE, {13'b0, mode});
        write_cfg(CFG_TPS, tps);
    endtask

    function automatic req_t rand_req();
        req_t q;
        int r;
        r = $urandom_range(0, 99);
        q.act = (r < 35) ? ACT_INBOUND : (r < 55) ? ACT_OUTBOUND :
                (r < 81) ? ACT_UPDATE : (r < 82) ? ACT_FLUSH : ACT_TICK;
        q.src = ($urandom_range(0, 9) == 0) ? $urandom() : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        q.dst = ($urandom_range(0, 9) == 0) ? $urandom() : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        q.verd = ($urandom_range(0, 1) == 0) ? VERD_RATE_LIMIT : 3'($urandom_range(0, 4));
        q.lim = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 4);
        q.dur = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 5));
        return q;
    endfunction

    initial begin
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        foreach (addr_pool[i]) addr_pool[i] = $urandom();
        addr_pool[0] = 32'h0;
        addr_pool[1] = 32'hFFFF_FFFF;
        k0 = addr_pool[2];
        k1 = addr_pool[3];
        k2 = addr_pool[4];
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_one(ACT_INBOUND, k0, k1, VERD_ALLOW, 0, 0);
        drain();
        set_all(1'b1, MODE_PROTECT, 16'd1);
        send_one(ACT_INBOUND, k0, k1, VERD_ALLOW, 0, 0);
        send_one(ACT_UPDATE, k0, k1, VERD_DROP, 0, 16'd5);
        send_one(ACT_INBOUND, k0, k1, VERD_ALLOW, 0, 0);
        send_one(ACT_OUTBOUND, k2, k0, VERD_ALLOW, 0, 0);
        send_one(ACT_UPDATE, k1, k0, VERD_RATE_LIMIT, 32'd2, 16'd0);
        repeat (3) send_one(ACT_INBOUND, k1, k0, VERD_ALLOW, 0, 0);
        repeat (2) send_one(ACT_TICK, k1, k0, VERD_ALLOW, 0, 0);
        send_one(ACT_INBOUND, k1, k0, VERD_ALLOW, 0, 0);
        send_one(ACT_UPDATE, k1, k0, VERD_RATE_LIMIT, 32'd0, 16'd3);
        send_one(ACT_INBOUND, k1, k0, VERD_ALLOW, 0, 0);
        send_one(ACT_UPDATE, k2, k0, VERD_QUARANTINE, 0, 16'd1);
        repeat (2) send_one(ACT_TICK, k1, k0, VERD_ALLOW, 0, 0);
        send_one(ACT_INBOUND, k2, k0, VERD_ALLOW, 0, 0);
        send_one(ACT_UPDATE, 32'hFFFF_FFFF, 0, VERD_REDIRECT, 32'hFFFF_FFFF, 16'hFFFF);
        send_one(ACT_OUTBOUND, 0, 32'hFFFF_FFFF, VERD_ALLOW, 0, 0);
        send_one(ACT_UNKNOWN, k0, k0, VERD_ALLOW, 0, 0);
        send_one(ACT_FLUSH, k0, k0, VERD_ALLOW, 0, 0);
        send_one(ACT_INBOUND, k0, k1, VERD_ALLOW, 0, 0);
        drain();
        write_cfg(CFG_TPS, 16'hFFFF);
        send_one(ACT_UPDATE, 32'h0, 0, VERD_DROP, 0, 16'hFFFF);
        send_one(ACT_INBOUND, 32'h0, 0, VERD_ALLOW, 0, 0);
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_all(1'b1, MODE_PROTECT, 16'd1);
                1: set_all(1'b1, MODE_QUARANTINE, 16'd3);
                2: set_all(1'b1, MODE_TOP, 16'd0);
                3: set_all(1'b0, MODE_PROTECT, 16'd2);
                4: set_all(1'b1, MODE_PROTECT, 16'hFFFF);
                default: set_all(1'b1, MODE_DETECT, 16'd2);
            endcase
            for (int n = 0; n < ((p == 3 || p == 5) ? 120 : 280); n++) send_req(rand_req());
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
